>>> hdl/rgb_to_hsv_converter_core_defines.svh
// ---------------------------------------------------------------------------
// RGB to HSV converter assertion macros
// Concurrent property checks, empty in synthesis builds.
// ---------------------------------------------------------------------------
`ifndef RGB_TO_HSV_CONVERTER_CORE_DEFINES_SVH
`define RGB_TO_HSV_CONVERTER_CORE_DEFINES_SVH

`ifndef SYNTHESIS
`define RHSV_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error("assertion failed");
`define RHSV_NEVER(lbl, cond) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) \
    else $error("forbidden condition");
`else
`define RHSV_ASSERT(lbl, prop)
`define RHSV_NEVER(lbl, cond)
`endif

`endif

>>> hdl/rgbhsv_pkg.sv
// ---------------------------------------------------------------------------
// RGB to HSV package
// Shared item types and constants.
// ---------------------------------------------------------------------------
package rgbhsv_pkg;

  localparam int unsigned HueQBits = 6;
  localparam int unsigned SatQBits = 7;

  localparam logic [8:0] Hue360  = 9'd360;
  localparam logic [8:0] Sector2 = 9'd120;
  localparam logic [8:0] Sector4 = 9'd240;

  typedef struct packed {
    logic [14:0] hnum;
    logic [7:0]  hden;
    logic [14:0] snum;
    logic [7:0]  sden;
    logic        neg;
    logic [8:0]  base;
    logic [6:0]  bright;
    logic        undef;
    logic        black;
  } front_t;

  typedef struct packed {
    logic [14:0]         hrem;
    logic [7:0]          hden;
    logic [HueQBits-1:0] hq;
    logic [14:0]         srem;
    logic [7:0]          sden;
    logic [SatQBits-1:0] sq;
    logic                neg;
    logic [8:0]          base;
    logic [6:0]          bright;
    logic                undef;
    logic                black;
  } stage_t;

endpackage

>>> hdl/rgbhsv_front.sv
// ---------------------------------------------------------------------------
// RGB to HSV front end
// Finds max/min, sector and difference, registers one classified item.
// ---------------------------------------------------------------------------
module rgbhsv_front (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                push_i,
  output logic                full_o,
  input  logic [7:0]          red_i,
  input  logic [7:0]          green_i,
  input  logic [7:0]          blue_i,
  output logic                valid_o,
  input  logic                ready_i,
  output rgbhsv_pkg::front_t  item_o
);
  import rgbhsv_pkg::*;

  logic        valid_q;
  front_t      item_q, item_d;
  logic [7:0]  mx, mn, delta, absd;
  logic [8:0]  diff;
  logic [14:0] vx;

  always_comb begin
    mx = (red_i > green_i) ? red_i : green_i;
    mn = (red_i < green_i) ? red_i : green_i;
    if (blue_i > mx) mx = blue_i;
    if (blue_i < mn) mn = blue_i;
    delta = mx - mn;
    if (red_i == mx) begin
      diff = {1'b0, green_i} - {1'b0, blue_i};
      item_d.base = '0;
    end else if (green_i == mx) begin
      diff = {1'b0, blue_i} - {1'b0, red_i};
      item_d.base = Sector2;
    end else begin
      diff = {1'b0, red_i} - {1'b0, green_i};
      item_d.base = Sector4;
    end
    absd = diff[8] ? 8'(-diff) : diff[7:0];
    vx = 15'(mx) * 15'd100;
    item_d.hnum   = 15'(absd) * 15'd60;
    item_d.hden   = delta;
    item_d.snum   = 15'(delta) * 15'd100;
    item_d.sden   = mx;
    item_d.neg    = diff[8];
    item_d.bright = 7'((vx + 15'd1 + (vx >> 8)) >> 8);
    item_d.undef  = (delta == '0);
    item_d.black  = (mx == '0);
  end

  assign full_o  = valid_q && !ready_i;
  assign valid_o = valid_q;
  assign item_o  = item_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (!full_o) begin
      valid_q <= push_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i && !full_o) begin
      item_q <= item_d;
    end
  end

endmodule

>>> hdl/rgbhsv_queue.sv
// ---------------------------------------------------------------------------
// RGB to HSV decoupling queue
// Small FIFO between front end and divider pipeline.
// ---------------------------------------------------------------------------
module rgbhsv_queue #(
  parameter int unsigned Depth = 4
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                push_i,
  input  rgbhsv_pkg::front_t  item_i,
  output logic                full_o,
  input  logic                pop_i,
  output rgbhsv_pkg::front_t  item_o,
  output logic                empty_o
);
  import rgbhsv_pkg::*;

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);

  front_t            mem_q [Depth];
  logic [PtrW-1:0]   wptr_q, rptr_q;
  logic [CntW-1:0]   cnt_q;
  logic              do_push, do_pop;

  assign full_o  = (cnt_q == CntW'(Depth));
  assign empty_o = (cnt_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign item_o  = mem_q[rptr_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      if (do_push) begin
        wptr_q <= (wptr_q == PtrW'(Depth - 1)) ? '0 : wptr_q + 1'b1;
      end
      if (do_pop) begin
        rptr_q <= (rptr_q == PtrW'(Depth - 1)) ? '0 : rptr_q + 1'b1;
      end
      cnt_q <= cnt_q + CntW'(do_push) - CntW'(do_pop);
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wptr_q] <= item_i;
    end
  end

endmodule

>>> hdl/rgbhsv_back.sv
// ---------------------------------------------------------------------------
// RGB to HSV back end
// Bit-per-stage restoring dividers for hue and saturation, output register.
// ---------------------------------------------------------------------------
module rgbhsv_back (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                valid_i,
  input  rgbhsv_pkg::front_t  item_i,
  output logic                take_o,
  output logic [8:0]          hue_o,
  output logic [6:0]          saturation_o,
  output logic [6:0]          brightness_o,
  output logic                hue_undefined_o,
  output logic                empty_o,
  input  logic                pop_i
);
  import rgbhsv_pkg::*;

  function automatic stage_t div_step(stage_t s, int unsigned hk, int unsigned sk,
                                      logic do_h);
    stage_t      r;
    logic [14:0] hd, sd;
    r  = s;
    hd = 15'(s.hden) << hk;
    sd = 15'(s.sden) << sk;
    if (do_h && (s.hrem >= hd)) begin
      r.hrem = s.hrem - hd;
      r.hq[hk[2:0]] = 1'b1;
    end
    if (s.srem >= sd) begin
      r.srem = s.srem - sd;
      r.sq[sk[2:0]] = 1'b1;
    end
    return r;
  endfunction

  stage_t     entry;
  stage_t     stage_q [SatQBits];
  logic       valid_q [SatQBits];
  logic       out_valid_q, en;
  logic [8:0] hue_q, hue_d;
  logic [6:0] sat_q, sat_d, bright_q;
  logic       undef_q;
  stage_t     last;

  assign en     = !out_valid_q || pop_i;
  assign take_o = en && valid_i;

  always_comb begin
    entry        = '0;
    entry.hrem   = item_i.hnum;
    entry.hden   = item_i.hden;
    entry.srem   = item_i.snum;
    entry.sden   = item_i.sden;
    entry.neg    = item_i.neg;
    entry.base   = item_i.base;
    entry.bright = item_i.bright;
    entry.undef  = item_i.undef;
    entry.black  = item_i.black;
  end

  for (genvar i = 0; i < SatQBits; i++) begin : g_stage
    localparam int unsigned SK = SatQBits - 1 - i;
    localparam int unsigned HK = (i < HueQBits) ? HueQBits - 1 - i : 0;
    localparam logic        DH = (i < HueQBits);
    stage_t in_s;
    logic   in_v;
    if (i == 0) begin : g_first
      assign in_s = entry;
      assign in_v = valid_i;
    end else begin : g_next
      assign in_s = stage_q[i-1];
      assign in_v = valid_q[i-1];
    end
    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        valid_q[i] <= 1'b0;
      end else if (en) begin
        valid_q[i] <= in_v;
      end
    end
    always_ff @(posedge clk_i) begin
      if (en) begin
        stage_q[i] <= div_step(in_s, HK, SK, DH);
      end
    end
  end

  assign last = stage_q[SatQBits-1];

  // negative difference: sector base (360 for red) minus the rounded-up quotient
  always_comb begin
    if (last.undef) begin
      hue_d = '0;
    end else if (last.neg) begin
      hue_d = ((last.base == '0) ? Hue360 : last.base) - 9'(last.hq)
              - 9'(last.hrem != '0);
    end else begin
      hue_d = last.base + 9'(last.hq);
    end
    sat_d = last.black ? '0 : last.sq;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (en) begin
      out_valid_q <= valid_q[SatQBits-1];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      hue_q    <= hue_d;
      sat_q    <= sat_d;
      bright_q <= last.bright;
      undef_q  <= last.undef;
    end
  end

  assign empty_o         = !out_valid_q;
  assign hue_o           = hue_q;
  assign saturation_o    = sat_q;
  assign brightness_o    = bright_q;
  assign hue_undefined_o = undef_q;

endmodule

>>> hdl/rgb_to_hsv_converter_core.sv
// A pixel passes the front register, queue, divider pipeline and output register.
// Throughput: one pixel per cycle unless pop stalls the 7-stage divider pipeline.
// Quotients resolve one bit per pipeline stage; hue stops after HueQBits stages.
// Reset (rst_ni low, asynchronous) empties the front register, queue and pipeline.
// ---------------------------------------------------------------------------
// RGB to HSV converter core
// 8-bit RGB pixel in, hue degrees and saturation/value percent out.
// ---------------------------------------------------------------------------
`include "rgb_to_hsv_converter_core_defines.svh"

module rgb_to_hsv_converter_core #(
  parameter int unsigned QueueDepth = 4
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       push,
  output logic       full,
  input  logic [7:0] red_i,
  input  logic [7:0] green_i,
  input  logic [7:0] blue_i,
  output logic       empty,
  input  logic       pop,
  output logic [8:0] hue_o,
  output logic [6:0] saturation_o,
  output logic [6:0] brightness_o,
  output logic       hue_undefined_o
);
  import rgbhsv_pkg::*;

  front_t fr_item, q_item;
  logic   fr_valid, q_full, q_empty, take;

  rgbhsv_front u_front (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .full_o  (full),
    .red_i   (red_i),
    .green_i (green_i),
    .blue_i  (blue_i),
    .valid_o (fr_valid),
    .ready_i (!q_full),
    .item_o  (fr_item)
  );

  rgbhsv_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (fr_valid),
    .item_i  (fr_item),
    .full_o  (q_full),
    .pop_i   (take),
    .item_o  (q_item),
    .empty_o (q_empty)
  );

  rgbhsv_back u_back (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .valid_i         (!q_empty),
    .item_i          (q_item),
    .take_o          (take),
    .hue_o           (hue_o),
    .saturation_o    (saturation_o),
    .brightness_o    (brightness_o),
    .hue_undefined_o (hue_undefined_o),
    .empty_o         (empty),
    .pop_i           (pop)
  );

  `RHSV_NEVER(a_hue_range, !empty && (hue_o >= Hue360))
  `RHSV_NEVER(a_sat_range, !empty && (saturation_o > 7'd100))
  `RHSV_ASSERT(a_undef_hue, (!empty && hue_undefined_o) |-> (hue_o == '0))
  `RHSV_ASSERT(a_sat_zero_gray, (!empty && hue_undefined_o) |-> (saturation_o == '0))

endmodule

>>> bench/tb_rgb_to_hsv_converter_core.sv
// ---------------------------------------------------------------------------
// RGB to HSV converter core testbench
// Drives directed and random pixels through the queue-style ports, predicts
// hue, saturation and value with exact integer math and checks every result.
// ---------------------------------------------------------------------------
module tb_rgb_to_hsv_converter_core;
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [8:0] hue;
    logic [6:0] sat;
    logic [6:0] val;
    logic       undef;
  } hsv_t;

  typedef struct {
    logic [7:0] r, g, b;
    logic       known;
    hsv_t       hsv;
  } pixel_row_t;

  logic       clk_i, rst_ni;
  logic       push, full, empty, pop;
  logic [7:0] red_i, green_i, blue_i;
  logic [8:0] hue_o;
  logic [6:0] saturation_o, brightness_o;
  logic       hue_undefined_o;

  hsv_t       hsv_expected[$];
  int         n_errors = 0;
  bit         sending_done = 0;
  bit         calm = 0;
  bit         held = 0;
  int         hold_cycles = 0;

  rgb_to_hsv_converter_core DUT (
    .clk_i, .rst_ni, .push, .full, .red_i, .green_i, .blue_i,
    .empty, .pop, .hue_o, .saturation_o, .brightness_o, .hue_undefined_o
  );

  initial begin
    clk_i = 0;
    forever #1 clk_i = ~clk_i;
  end

  initial begin
    #200000;
    $display("FAILURE");
    $finish;
  end

  function automatic hsv_t rgb_to_hsv(logic [7:0] r, logic [7:0] g, logic [7:0] b);
    int   mx, mn, dl, sector, diff, num;
    hsv_t h;
    mx = r; mn = r;
    if (g > mx) mx = g;
    if (b > mx) mx = b;
    if (g < mn) mn = g;
    if (b < mn) mn = b;
    dl = mx - mn;
    h = '0;
    h.undef = 1'b1;
    if (mx == 0) return h;
    h.val = 7'((100 * mx) / 255);
    if (dl == 0) return h;
    h.sat = 7'((100 * dl) / mx);
    h.undef = 1'b0;
    if (r == mx) begin
      sector = 0; diff = int'(g) - int'(b);
    end else if (g == mx) begin
      sector = 2; diff = int'(b) - int'(r);
    end else begin
      sector = 4; diff = int'(r) - int'(g);
    end
    num = 60 * sector * dl + 60 * diff;
    if (num < 0) num += 360 * dl;
    h.hue = 9'(num / dl);
    return h;
  endfunction

  function automatic pixel_row_t row(int r, int g, int b, bit k = 0,
                                     int h = 0, int s = 0, int v = 0, int u = 0);
    pixel_row_t p;
    p.r = 8'(r); p.g = 8'(g); p.b = 8'(b); p.known = k;
    p.hsv = '{hue: 9'(h), sat: 7'(s), val: 7'(v), undef: 1'(u)};
    return p;
  endfunction

  pixel_row_t pixel_table[] = '{
    row(0, 0, 0, 1, 0, 0, 0, 1),
    row(255, 255, 255, 1, 0, 0, 100, 1),
    row(128, 128, 128, 1, 0, 0, 50, 1),
    row(1, 1, 1, 1, 0, 0, 0, 1),
    row(255, 0, 0, 1, 0, 100, 100, 0),
    row(0, 255, 0, 1, 120, 100, 100, 0),
    row(0, 0, 255, 1, 240, 100, 100, 0),
    row(255, 255, 0), row(255, 0, 255), row(0, 255, 255),
    row(255, 0, 1), row(255, 1, 0), row(1, 0, 0), row(0, 1, 0), row(0, 0, 1),
    row(200, 200, 10), row(10, 200, 200), row(200, 10, 200),
    row(255, 254, 0), row(170, 85, 255), row(85, 170, 85), row(254, 255, 253),
    row(2, 1, 0), row(0, 2, 1), row(1, 0, 2),
    row(10, 200, 50), row(50, 10, 200)
  };

  task automatic send(logic [7:0] r, logic [7:0] g, logic [7:0] b);
    push <= 1'b1; red_i <= r; green_i <= g; blue_i <= b;
    do @(posedge clk_i); while (full);
    hsv_expected.push_back(rgb_to_hsv(r, g, b));
  endtask

  initial begin
    hsv_t hsv;
    push = 0; red_i = 0; green_i = 0; blue_i = 0;
    rst_ni = 0;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1;
    @(posedge clk_i);
    foreach (pixel_table[i]) begin
      if (pixel_table[i].known) begin
        hsv = rgb_to_hsv(pixel_table[i].r, pixel_table[i].g, pixel_table[i].b);
        if (hsv !== pixel_table[i].hsv) begin
          $error("table row %0d: expected %h, predictor %h", i, pixel_table[i].hsv, hsv);
          n_errors++;
        end
      end
      send(pixel_table[i].r, pixel_table[i].g, pixel_table[i].b);
    end
    for (int i = 0; i < 1250; i++) begin
      calm = (i >= 500 && i < 700);
      if (!calm && $urandom_range(99) < 13) begin
        push <= 1'b0;
        repeat ($urandom_range(1, 4)) @(posedge clk_i);
      end
      case ($urandom_range(3))
        0: begin
          send(8'($urandom), 8'($urandom), 8'($urandom));
        end
        1: begin
          // gray or near-gray
          logic [7:0] base;
          base = 8'($urandom);
          send(base, base + 8'($urandom_range(0, 2)), base - 8'($urandom_range(0, 1)));
        end
        default: send(8'($urandom), 8'($urandom), 8'($urandom));
      endcase
    end
    push <= 1'b0;
    sending_done = 1;
  end

  // Result side
  initial begin
    hsv_t exp_hsv;
    pop = 0;
    @(posedge rst_ni);
    forever begin
      if (!held && hsv_expected.size() >= 8) begin
        held = 1;
        hold_cycles = 60;
      end
      if (hold_cycles > 0) begin
        hold_cycles--;
        pop <= 1'b0;
      end else begin
        pop <= calm || $urandom_range(99) >= 13;
      end
      @(posedge clk_i);
      if (pop && !empty) begin
        if (hsv_expected.size() == 0) begin
          $error("result transfer with nothing expected");
          n_errors++;
        end else begin
          exp_hsv = hsv_expected.pop_front();
          if (hue_o !== exp_hsv.hue) begin
            $error("hue: expected %0d, got %0d", exp_hsv.hue, hue_o); n_errors++;
          end
          if (saturation_o !== exp_hsv.sat) begin
            $error("saturation: expected %0d, got %0d", exp_hsv.sat, saturation_o);
            n_errors++;
          end
          if (brightness_o !== exp_hsv.val) begin
            $error("brightness: expected %0d, got %0d", exp_hsv.val, brightness_o);
            n_errors++;
          end
          if (hue_undefined_o !== exp_hsv.undef) begin
            $error("hue_undefined: expected %0d, got %0d", exp_hsv.undef,
                   hue_undefined_o);
            n_errors++;
          end
        end
      end
    end
  end

  initial begin
    wait (sending_done);
    while (hsv_expected.size() != 0) @(posedge clk_i);
    repeat (30) @(posedge clk_i);
    if (n_errors == 0 && hsv_expected.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
